[rtl/assert_macros.svh]
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_AT(lbl, clk, rst, !(expr), msg)

`endif

[rtl/zcd_pkg.sv]
// Package: constants, codes and queue types of the central directory parser.
package zcd_pkg;

   localparam logic [31:0] ENTRY_SIG   = 32'h0201_4b50;
   localparam logic [31:0] ESCAPE32    = 32'hffff_ffff;
   localparam int          HEADER_LEN  = 46;
   localparam int          ENCRYPT_BIT = 0;
   localparam int          POS_W       = 18;
   localparam int          CSR_INDEX_W = 4;
   localparam int          QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_TOTAL     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTORY_BYTES = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      KIND_NAME   = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_MALFORMED = 2'd0,
      ERR_OVERRUN   = 2'd1,
      ERR_ENCRYPTED = 2'd2,
      ERR_ZIP64     = 2'd3
   } err_type;

   // One queue entry: an optional name byte, then an optional record or error.
   typedef struct packed {
      logic        has_name;
      logic [7:0]  name_char;
      logic        has_tail;
      logic        tail_err;
      err_type     error_code;
      logic [15:0] method_code;
      logic [31:0] crc_value;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [31:0] header_offset;
      logic [15:0] name_bytes;
      logic        final_entry;
   } op_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } q_wr_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } q_rd_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [7:0]  name_char;
      logic [15:0] method_code;
      logic [31:0] crc_value;
      logic [31:0] packed_size;
      logic [31:0] plain_size;
      logic [31:0] header_offset;
      logic [15:0] name_bytes;
      err_type     error_code;
      logic        final_entry;
   } res_type;

endpackage

[rtl/zcd_req_if.sv]
// Interface: byte input channel of the parser.
interface zcd_req_if import zcd_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_directory;

   modport source (output valid, data_byte, start_of_directory, input ready);
   modport sink   (input valid, data_byte, start_of_directory, output ready);
endinterface

[rtl/zcd_rsp_if.sv]
// Interface: result channel of the parser.
interface zcd_rsp_if import zcd_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [7:0]  name_char;
   logic [15:0] method_code;
   logic [31:0] crc_value;
   logic [31:0] packed_size;
   logic [31:0] plain_size;
   logic [31:0] header_offset;
   logic [15:0] name_bytes;
   logic [1:0]  error_code;
   logic        final_entry;

   modport source (output valid, result_kind, name_char, method_code, crc_value,
                   packed_size, plain_size, header_offset, name_bytes, error_code,
                   final_entry, input ready);
   modport sink   (input valid, result_kind, name_char, method_code, crc_value,
                   packed_size, plain_size, header_offset, name_bytes, error_code,
                   final_entry, output ready);
endinterface

[rtl/zcd_csr_if.sv]
// Interface: configuration write channel of the parser.
interface zcd_csr_if import zcd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [31:0]            data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/zcd_front.sv]
// Front end: configuration registers, byte position tracking and field capture.
`include "assert_macros.svh"

module zcd_front import zcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   zcd_req_if.sink  req_bus,
   zcd_csr_if.sink  csr_bus,
   input  logic     q_not_full,
   output q_wr_type wr
);

   localparam logic [5:0] P_SIG_LAST  = 6'd3;
   localparam logic [5:0] P_FLAG_LO   = 6'd8;
   localparam logic [5:0] P_FLAG_HI   = 6'd9;
   localparam logic [5:0] P_METH_LO   = 6'd10;
   localparam logic [5:0] P_METH_HI   = 6'd11;
   localparam logic [5:0] P_CRC_LO    = 6'd16;
   localparam logic [5:0] P_CRC_HI    = 6'd19;
   localparam logic [5:0] P_PACK_LO   = 6'd20;
   localparam logic [5:0] P_PACK_HI   = 6'd23;
   localparam logic [5:0] P_PLAIN_LO  = 6'd24;
   localparam logic [5:0] P_PLAIN_HI  = 6'd27;
   localparam logic [5:0] P_LEN_LO    = 6'd28;
   localparam logic [5:0] P_LEN_HI    = 6'd33;
   localparam logic [5:0] P_OFS_LO    = 6'd42;
   localparam logic [5:0] P_HDR_LAST  = 6'(HEADER_LEN - 1);

   logic [15:0]      entry_total_ff;
   logic [31:0]      directory_bytes_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      bytes_left_ff, bytes_left_in;
   logic [15:0]      done_ff, done_in;
   logic             halted_ff, halted_in;
   logic [31:0]      sig_ff, sig_in;
   logic [15:0]      flag_ff, flag_in;
   logic [15:0]      method_ff, method_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      packed_ff, packed_in;
   logic [31:0]      plain_ff, plain_in;
   logic [31:0]      offset_ff, offset_in;
   logic [15:0]      len_ff [3];
   logic [15:0]      len_in [3];
   // Entry bounds, recomputed every cycle from the stable length fields.
   logic [POS_W-1:0] total_ff, total_in;
   logic [POS_W-1:0] name_last_ff, name_last_in;
   logic [POS_W-1:0] entry_last_ff, entry_last_in;

   logic             acc, start_acc, active, short_hdr, live, in_hdr;
   logic [POS_W-1:0] pos_e;
   logic [31:0]      bytes_left_e;
   logic [15:0]      done_e, done_inc;
   logic [5:0]       hp;
   logic             bad_sig, hdr_end, overrun, hdr_finish;
   logic             in_name, name_last, do_finish, fin_bad, fin_ok, err;
   logic             ext_zero;
   err_type          err_code;
   logic [1:0]       len_sel;

   assign acc         = req_bus.valid && req_bus.ready;
   assign start_acc   = acc && req_bus.start_of_directory;
   assign req_bus.ready = q_not_full;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      total_in      = POS_W'(len_ff[0]) + POS_W'(len_ff[1]) + POS_W'(len_ff[2]);
      name_last_in  = POS_W'(len_ff[0]) + POS_W'(HEADER_LEN - 1);
      entry_last_in = total_ff + POS_W'(HEADER_LEN - 1);
   end

   always_comb begin
      pos_e        = start_acc ? '0 : pos_ff;
      bytes_left_e = start_acc ? directory_bytes_ff : bytes_left_ff;
      done_e       = start_acc ? '0 : done_ff;
      active       = acc && !(start_acc ? 1'b0 : halted_ff) && (done_e < entry_total_ff);
      in_hdr       = pos_e < POS_W'(HEADER_LEN);
      hp           = pos_e[5:0];
      short_hdr    = active && (pos_e == '0) && (bytes_left_e < 32'(HEADER_LEN));
      live         = active && !short_hdr;
      done_inc     = done_e + 16'd1;
      ext_zero     = (len_ff[1] == '0) && (len_ff[2] == '0);
      len_sel      = 2'((hp - P_LEN_LO) >> 1);
   end

   // Field capture: little-endian fields shift in from the top.
   always_comb begin
      sig_in    = sig_ff;
      flag_in   = flag_ff;
      method_in = method_ff;
      crc_in    = crc_ff;
      packed_in = packed_ff;
      plain_in  = plain_ff;
      offset_in = offset_ff;
      len_in    = len_ff;
      if (live && in_hdr) begin
         if (hp <= P_SIG_LAST) begin
            sig_in = {req_bus.data_byte, sig_ff[31:8]};
         end else if (hp == P_FLAG_LO || hp == P_FLAG_HI) begin
            flag_in = {req_bus.data_byte, flag_ff[15:8]};
         end else if (hp == P_METH_LO || hp == P_METH_HI) begin
            method_in = {req_bus.data_byte, method_ff[15:8]};
         end else if (hp >= P_CRC_LO && hp <= P_CRC_HI) begin
            crc_in = {req_bus.data_byte, crc_ff[31:8]};
         end else if (hp >= P_PACK_LO && hp <= P_PACK_HI) begin
            packed_in = {req_bus.data_byte, packed_ff[31:8]};
         end else if (hp >= P_PLAIN_LO && hp <= P_PLAIN_HI) begin
            plain_in = {req_bus.data_byte, plain_ff[31:8]};
         end else if (hp >= P_LEN_LO && hp <= P_LEN_HI) begin
            len_in[len_sel] = {req_bus.data_byte, len_ff[len_sel][15:8]};
         end else if (hp >= P_OFS_LO) begin
            offset_in = {req_bus.data_byte, offset_ff[31:8]};
         end
      end
   end

   // Classify the byte.
   always_comb begin
      bad_sig    = live && in_hdr && (hp == P_SIG_LAST) && (sig_in != ENTRY_SIG);
      hdr_end    = live && in_hdr && (hp == P_HDR_LAST);
      // bytes_left is at least one here, so (left - 1 < total) is (left <= total).
      overrun    = hdr_end && (bytes_left_e <= 32'(total_ff));
      hdr_finish = hdr_end && !overrun && (len_ff[0] == '0);
      in_name    = live && !in_hdr && (pos_e <= name_last_ff);
      name_last  = in_name && (pos_e == name_last_ff);
      do_finish  = hdr_finish || name_last;
      fin_bad    = do_finish && (flag_ff[ENCRYPT_BIT] || packed_ff == ESCAPE32 ||
                                 plain_ff == ESCAPE32 || offset_in == ESCAPE32);
      fin_ok     = do_finish && !fin_bad;
      err        = short_hdr || bad_sig || overrun || fin_bad;
      if (overrun) begin
         err_code = ERR_OVERRUN;
      end else if (fin_bad) begin
         err_code = flag_ff[ENCRYPT_BIT] ? ERR_ENCRYPTED : ERR_ZIP64;
      end else begin
         err_code = ERR_MALFORMED;
      end
   end

   // Next position, count and halt state.
   always_comb begin
      pos_in        = start_acc ? '0 : pos_ff;
      bytes_left_in = bytes_left_e;
      done_in       = done_e;
      halted_in     = start_acc ? 1'b0 : halted_ff;
      if (!acc) begin
         bytes_left_in = bytes_left_ff;
         done_in       = done_ff;
      end
      if (live && bytes_left_e != '0) begin
         bytes_left_in = bytes_left_e - 32'd1;
      end
      if (live) begin
         if (fin_ok) begin
            pos_in = ext_zero ? '0 : name_last_ff + POS_W'(1);
         end else if (!in_hdr && !in_name && pos_e >= entry_last_ff) begin
            pos_in = '0;
         end else begin
            pos_in = pos_e + POS_W'(1);
         end
      end
      if (fin_ok) begin
         done_in = done_inc;
      end
      if (err) begin
         halted_in = 1'b1;
      end
   end

   always_comb begin
      wr.push             = in_name || err || fin_ok;
      wr.op.has_name      = in_name;
      wr.op.name_char     = req_bus.data_byte;
      wr.op.has_tail      = err || fin_ok;
      wr.op.tail_err      = err;
      wr.op.error_code    = err_code;
      wr.op.method_code   = method_ff;
      wr.op.crc_value     = crc_ff;
      wr.op.packed_size   = packed_ff;
      wr.op.plain_size    = plain_ff;
      wr.op.header_offset = offset_in;
      wr.op.name_bytes    = len_ff[0];
      wr.op.final_entry   = (done_inc == entry_total_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_total_ff     <= '0;
         directory_bytes_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ENTRY_TOTAL:     entry_total_ff     <= csr_bus.data[15:0];
            CSR_DIRECTORY_BYTES: directory_bytes_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         bytes_left_ff <= '0;
         done_ff       <= '0;
         halted_ff     <= 1'b1;
         sig_ff        <= '0;
         flag_ff       <= '0;
         method_ff     <= '0;
         crc_ff        <= '0;
         packed_ff     <= '0;
         plain_ff      <= '0;
         offset_ff     <= '0;
         len_ff        <= '{default: '0};
         total_ff      <= '0;
         name_last_ff  <= POS_W'(HEADER_LEN - 1);
         entry_last_ff <= POS_W'(HEADER_LEN - 1);
      end else begin
         pos_ff        <= pos_in;
         bytes_left_ff <= bytes_left_in;
         done_ff       <= done_in;
         halted_ff     <= halted_in;
         sig_ff        <= sig_in;
         flag_ff       <= flag_in;
         method_ff     <= method_in;
         crc_ff        <= crc_in;
         packed_ff     <= packed_in;
         plain_ff      <= plain_in;
         offset_ff     <= offset_in;
         len_ff        <= len_in;
         total_ff      <= total_in;
         name_last_ff  <= name_last_in;
         entry_last_ff <= entry_last_in;
      end
   end

   `ASSERT_AT(a_halted_quiet, clock, reset, (acc && halted_ff && !req_bus.start_of_directory) |-> !wr.push, "halted parser queued a result")

endmodule

[rtl/zcd_queue.sv]
// Short queue between the front end and the result stage.
`include "assert_macros.svh"

module zcd_queue import zcd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  q_wr_type wr,
   output logic     not_full,
   input  logic     pop,
   output q_rd_type rd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign not_full = count_ff != CNT_W'(DEPTH);
   assign rd.valid = count_ff != '0;
   assign rd.op    = slots_ff[rd_ptr_ff];
   assign do_pop   = pop && rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr.push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!wr.push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         slots_ff[wr_ptr_ff] <= wr.op;
      end
   end

   `ASSERT_NEVER(a_no_push_full, clock, reset, wr.push && (count_ff == CNT_W'(DEPTH)), "push into a full queue")
   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(DEPTH), "queue count past depth")

endmodule

[rtl/zcd_back.sv]
// Result stage: splits queue entries into results and holds them in the output register.
`include "assert_macros.svh"

module zcd_back import zcd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  q_rd_type  rd,
   output logic      pop,
   zcd_rsp_if.source rsp_bus
);

   logic    valid_ff, valid_in;
   logic    phase_ff, phase_in;
   res_type res_ff, res_in;
   logic    load;

   assign load = !valid_ff || rsp_bus.ready;

   always_comb begin
      pop      = 1'b0;
      phase_in = phase_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = rd.valid;
         if (rd.valid) begin
            res_in = '0;
            if (rd.op.has_name && !phase_ff) begin
               res_in.result_kind = KIND_NAME;
               res_in.name_char   = rd.op.name_char;
               if (rd.op.has_tail) begin
                  phase_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               pop      = 1'b1;
               phase_in = 1'b0;
               if (rd.op.tail_err) begin
                  res_in.result_kind = KIND_ERROR;
                  res_in.error_code  = rd.op.error_code;
               end else begin
                  res_in.result_kind   = KIND_RECORD;
                  res_in.method_code   = rd.op.method_code;
                  res_in.crc_value     = rd.op.crc_value;
                  res_in.packed_size   = rd.op.packed_size;
                  res_in.plain_size    = rd.op.plain_size;
                  res_in.header_offset = rd.op.header_offset;
                  res_in.name_bytes    = rd.op.name_bytes;
                  res_in.final_entry   = rd.op.final_entry;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.result_kind   = res_ff.result_kind;
   assign rsp_bus.name_char     = res_ff.name_char;
   assign rsp_bus.method_code   = res_ff.method_code;
   assign rsp_bus.crc_value     = res_ff.crc_value;
   assign rsp_bus.packed_size   = res_ff.packed_size;
   assign rsp_bus.plain_size    = res_ff.plain_size;
   assign rsp_bus.header_offset = res_ff.header_offset;
   assign rsp_bus.name_bytes    = res_ff.name_bytes;
   assign rsp_bus.error_code    = res_ff.error_code;
   assign rsp_bus.final_entry   = res_ff.final_entry;

   `ASSERT_AT(a_phase_head, clock, reset, phase_ff |-> (rd.valid && rd.op.has_name && rd.op.has_tail), "second half pending without a two-result head")

endmodule

[rtl/zip_central_directory_parser.sv]
// A result is registered in the queue and then in the output register before it is shown.
// Throughput: one byte per cycle while the queue is not full; a byte that yields a name byte
// and a record or error loads the result register twice; the QUEUE_DEPTH-entry queue absorbs it.
// Reset (synchronous, active high): clears control state; config reads zero and the parser
// stays halted, dropping bytes, until a byte with start_of_directory arrives.
// A start byte reloads the byte budget, clears the entry count and errors.
module zip_central_directory_parser import zcd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   zcd_req_if.sink   req_bus,
   zcd_rsp_if.source rsp_bus,
   zcd_csr_if.sink   csr_bus
);

   q_wr_type wr;
   q_rd_type rd;
   logic     q_not_full;
   logic     pop;

   // Front end: track the byte position in the entry, capture the header fields,
   // and turn each byte into at most one queue entry (name byte, record, error).
   zcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .q_not_full (q_not_full),
      .wr         (wr)
   );

   // Decouple classification from delivery so an output stall does not stall
   // the byte stream until the queue fills.
   zcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .not_full (q_not_full),
      .pop      (pop),
      .rd       (rd)
   );

   // Result stage: emit the name byte first, then the record or error; advance
   // the queue once both parts of an entry have moved out.
   zcd_back u_back (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule
